// File: rtl/core/cpd_pkg.sv
// Shared constants and types for the capsule point distance block.
package cpd_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int LEN_W     = 15;
  localparam int OUT_W     = 18;
  localparam int OUT_MAX   = 131071;
  localparam int OUT_MIN   = -131072;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_SEG_LENGTH = 3'd3,
    REG_CAP_RADIUS = 3'd4
  } cfg_reg_e;

endpackage

// File: rtl/core/capsule_point_distance.sv
// Capsule point distance: streamed point against one Y-aligned capsule, pipelined.
// Pipeline: a one-bit-per-stage square root of RW stages plus six fixed stages.
// Throughput: one request per cycle, busy_o stays low; the receiver cannot stall.
// Reset: asynchronous, zeroes config and valid regs (not data), empties the pipeline.
module capsule_point_distance #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [((COORD_WIDTH > cpd_pkg::LEN_W) ? COORD_WIDTH : cpd_pkg::LEN_W)-1:0]
                                              cfg_wdata_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [COORD_WIDTH-1:0]       point_x_i,
  input  logic signed [COORD_WIDTH-1:0]       point_y_i,
  input  logic signed [COORD_WIDTH-1:0]       point_z_i,
  output logic                                result_valid_o,
  output logic signed [cpd_pkg::OUT_W-1:0]    surface_distance_o,
  output logic                                inside_res_o
);

  localparam int W     = COORD_WIDTH;
  localparam int LW    = cpd_pkg::LEN_W;
  localparam int YW    = ((W + 1 > LW + 1) ? W + 1 : LW + 1) + 1;
  localparam int EW    = YW + 1;
  localparam int MW    = (EW - 1 > 31) ? 31 : EW - 1;
  localparam int RW    = MW + 1;
  localparam int SW    = 2 * RW;
  localparam int REMW  = RW + 3;
  localparam int DFW   = RW + 2;
  localparam int LAT   = RW + 6;
  localparam logic [EW-1:0] MAG_CAP = EW'((64'd1 << MW) - 64'd1);

  // configuration
  logic signed [W-1:0]  origin_x_q, origin_y_q, origin_z_q;
  logic [LW-1:0]        segment_length_q, cap_radius_q;
  logic signed [YW-1:0] lo_q, hi_q, lo_d, hi_d;
  logic [31:0]          rsq_q, rsq_d, r2_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q       <= '0;
      origin_y_q       <= '0;
      origin_z_q       <= '0;
      segment_length_q <= '0;
      cap_radius_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpd_pkg::REG_ORIGIN_X:   origin_x_q       <= cfg_wdata_i[W-1:0];
        cpd_pkg::REG_ORIGIN_Y:   origin_y_q       <= cfg_wdata_i[W-1:0];
        cpd_pkg::REG_ORIGIN_Z:   origin_z_q       <= cfg_wdata_i[W-1:0];
        cpd_pkg::REG_SEG_LENGTH: segment_length_q <= cfg_wdata_i[LW-1:0];
        cpd_pkg::REG_CAP_RADIUS: cap_radius_q     <= cfg_wdata_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // segment ends (Q.1, one fractional bit) and squared radius (Q.2)
  assign lo_d   = {{(YW-W-1){origin_y_q[W-1]}}, origin_y_q, 1'b0}
                - {{(YW-LW){1'b0}}, segment_length_q};
  assign hi_d   = {{(YW-W-1){origin_y_q[W-1]}}, origin_y_q, 1'b0}
                + {{(YW-LW){1'b0}}, segment_length_q};
  assign r2_ext = {{(32-LW-1){1'b0}}, cap_radius_q, 1'b0};
  assign rsq_d  = r2_ext * r2_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q  <= '0;
      hi_q  <= '0;
      rsq_q <= '0;
    end else begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      rsq_q <= rsq_d;
    end
  end

  assign busy_o = 1'b0;

  // stage 0: capture request
  logic                vld0_q;
  logic signed [W-1:0] px_q, py_q, pz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
      pz_q <= point_z_i;
    end
  end

  // stage 1: axis differences, y against clamped segment
  logic                vld1_q;
  logic signed [EW-1:0] pxe, pye, pze, oxe, oze, loe, hie, dlo, dhi;
  logic signed [EW-1:0] dx_d, dy_d, dz_d, dx_q, dy_q, dz_q;

  assign pxe = {{(EW-W-1){px_q[W-1]}}, px_q, 1'b0};
  assign pye = {{(EW-W-1){py_q[W-1]}}, py_q, 1'b0};
  assign pze = {{(EW-W-1){pz_q[W-1]}}, pz_q, 1'b0};
  assign oxe = {{(EW-W-1){origin_x_q[W-1]}}, origin_x_q, 1'b0};
  assign oze = {{(EW-W-1){origin_z_q[W-1]}}, origin_z_q, 1'b0};
  assign loe = {lo_q[YW-1], lo_q};
  assign hie = {hi_q[YW-1], hi_q};
  assign dlo = pye - loe;
  assign dhi = pye - hie;
  assign dx_d = pxe - oxe;
  assign dz_d = pze - oze;

  always_comb begin
    if (dlo[EW-1]) begin
      dy_d = dlo;
    end else if (!dhi[EW-1] && (dhi != '0)) begin
      dy_d = dhi;
    end else begin
      dy_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
    dz_q <= dz_d;
  end

  // stage 2: magnitudes, capped
  function automatic logic [MW-1:0] mag_f(input logic [EW-1:0] d);
    logic [EW-1:0] a;
    a = d[EW-1] ? (~d + 1'b1) : d;
    return (a > MAG_CAP) ? MAG_CAP[MW-1:0] : a[MW-1:0];
  endfunction

  logic          vld2_q;
  logic [MW-1:0] mx_q, my_q, mz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= mag_f(dx_q);
    my_q <= mag_f(dy_q);
    mz_q <= mag_f(dz_q);
  end

  // stage 3: squares
  logic            vld3_q;
  logic [2*MW-1:0] sx_q, sy_q, sz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q <= mx_q * mx_q;
    sy_q <= my_q * my_q;
    sz_q <= mz_q * mz_q;
  end

  // stage 4: squared distance; sqrt stages follow, one root bit each
  logic            vld_q  [0:RW];
  logic [SW-1:0]   rad_q  [0:RW-1];
  logic [REMW-1:0] rem_q  [0:RW-1];
  logic [RW-1:0]   root_q [0:RW];
  logic            ins_q  [1:RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= {2'b00, sx_q} + {2'b00, sy_q} + {2'b00, sz_q};
    rem_q[0]  <= '0;
    root_q[0] <= '0;
  end

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic [REMW-1:0] cur, trial;
    logic            take;

    assign cur   = {rem_q[j][REMW-3:0], rad_q[j][SW-1:SW-2]};
    assign trial = {1'b0, root_q[j], 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      root_q[j+1] <= {root_q[j][RW-2:0], take};
    end

    if (j < RW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rad_q[j+1] <= {rad_q[j][SW-3:0], 2'b00};
        rem_q[j+1] <= take ? (cur - trial) : cur;
      end
    end

    if (j == 0) begin : g_ins_first
      always_ff @(posedge clk_i) begin
        ins_q[1] <= (rad_q[0] <= {{(SW-32){1'b0}}, rsq_q});
      end
    end else begin : g_ins_pass
      always_ff @(posedge clk_i) begin
        ins_q[j+1] <= ins_q[j];
      end
    end
  end

  // output stage: subtract the doubled radius from the root, halve with floor, saturate
  logic signed [DFW-1:0] diff, half, sat;

  assign diff = $signed({2'b00, root_q[RW]})
              - $signed({{(DFW-LW-1){1'b0}}, cap_radius_q, 1'b0});
  assign half = diff >>> 1;

  always_comb begin
    if (half > $signed(DFW'(cpd_pkg::OUT_MAX))) begin
      sat = DFW'(cpd_pkg::OUT_MAX);
    end else if (half < $signed(DFW'(cpd_pkg::OUT_MIN))) begin
      sat = DFW'(cpd_pkg::OUT_MIN);
    end else begin
      sat = half;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= vld_q[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    surface_distance_o <= sat[cpd_pkg::OUT_W-1:0];
    inside_res_o       <= ins_q[RW];
  end

  a_lat_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(LAT) result_valid_o)
    else $error("request did not produce a result at the expected latency");

  a_lat_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##(LAT) !result_valid_o)
    else $error("result strobe without a matching request");

  a_inside_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && inside_res_o) |->
      (surface_distance_o[cpd_pkg::OUT_W-1] || (surface_distance_o == '0)))
    else $error("inside flag set with positive surface distance");

  a_outside_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !inside_res_o) |-> !surface_distance_o[cpd_pkg::OUT_W-1])
    else $error("outside point with negative surface distance");

endmodule
